// ----- rtl/fdr_pkg.sv -----
// ----------------------------------------------------------------------------
// fdr_pkg
// Shared types and constants for the frame descriptor ring.
// ----------------------------------------------------------------------------
package fdr_pkg;
    localparam int MaxBlocks  = 16;
    localparam int IdxW       = $clog2(MaxBlocks);
    localparam int CntW       = $clog2(MaxBlocks + 1);
    localparam int OffsetBits = 24;

    typedef enum logic [2:0] {
        OP_WRITE = 3'd0,
        OP_PEEK  = 3'd1,
        OP_ADV   = 3'd2,
        OP_BACK  = 3'd3,
        OP_FORGET= 3'd4,
        OP_RANGE = 3'd5
    } t_op;

    localparam logic [1:0] REG_BUF_SIZE = 2'd0;
    localparam logic [1:0] REG_NUM_BLK  = 2'd1;
    localparam logic [1:0] REG_DATA_BASE= 2'd2;

    typedef struct packed {
        logic [24:0] offset;
        logic [23:0] hdr;
        logic [23:0] dlen;
        logic [31:0] user;
        logic [31:0] ts;
    } t_desc;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_PEEK,
        ST_WALK,
        ST_DONE
    } t_state;
endpackage

// ----- rtl/frame_descriptor_ring.sv -----
// ----------------------------------------------------------------------------
// frame_descriptor_ring
// Ring of frame descriptors over a contiguous byte buffer.
// ----------------------------------------------------------------------------
// Writes, advance, step back and forget give their result in the cycle after
// start; peek first reads one descriptor from memory; the timestamp range
// walks the pending entries, num_blocks-1 at most in a full ring, with one
// descriptor read per cycle from the single read port. busy is high until
// the result strobe; results must be taken in the strobe cycle.
module frame_descriptor_ring import fdr_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    input  logic        start,
    output logic        busy,
    input  logic [2:0]  i_op,
    input  logic [23:0] i_hdr_len,
    input  logic [23:0] i_data_len,
    input  logic [31:0] i_user,
    input  logic [31:0] i_ts,
    output logic        o_valid,
    output logic        o_ok,
    output logic [24:0] o_offset,
    output logic [23:0] o_entry_hdr_len,
    output logic [23:0] o_entry_data_len,
    output logic [31:0] o_entry_user,
    output logic [31:0] o_entry_ts,
    output logic [31:0] o_ts_min,
    output logic [31:0] o_ts_max,
    output logic [31:0] o_ts_span,
    output logic [31:0] o_frames_written,
    output logic [31:0] o_frames_read
);
    logic [23:0] r_buf_size, r_data_base;
    logic [4:0]  r_num_blocks;
    logic [IdxW-1:0] r_widx, r_ridx, r_walk;
    logic        r_rvalid;
    logic [23:0] r_woff;
    logic [31:0] r_wtot, r_rtot;
    t_state      r_state, n_state;
    logic        r_first;
    logic [31:0] r_min, r_max;

    logic        r_valid, r_ok;
    logic [24:0] r_offset;
    logic        r_peek_out;

    logic        accept;
    logic [CntW-1:0] nb;
    logic [IdxW-1:0] nb_last;
    logic        widx_in, ridx_ok, empty;
    logic [IdxW-1:0] snap, snap_nxt;
    logic [24:0] wsum;
    logic        w_ok;
    logic [23:0] base_off;
    logic [IdxW-1:0] wi;
    t_desc       wdesc, rdata;
    logic        we;
    logic [IdxW-1:0] raddr;
    logic [1:0]  cfg_addr;

    assign pready   = 1'b1;
    assign cfg_addr = paddr[3:2];
    assign accept   = start && !busy;

    always_comb begin
        case (cfg_addr)
            REG_BUF_SIZE:  prdata = {8'd0, r_buf_size};
            REG_NUM_BLK:   prdata = {27'd0, r_num_blocks};
            REG_DATA_BASE: prdata = {8'd0, r_data_base};
            default:       prdata = 32'd0;
        endcase
    end

    always_comb begin
        if (r_num_blocks == 5'd0) begin
            nb = CntW'(1);
        end else if (r_num_blocks > 5'(MaxBlocks)) begin
            nb = CntW'(MaxBlocks);
        end else begin
            nb = CntW'(r_num_blocks);
        end
        nb_last = IdxW'(nb - CntW'(1));
        widx_in = CntW'(r_widx) < nb;
        ridx_ok = r_rvalid && (CntW'(r_ridx) < nb);
        snap    = ridx_ok ? r_ridx : r_widx;
        empty   = !widx_in || (r_widx == snap);
        snap_nxt = (snap == nb_last) ? '0 : snap + 1'b1;
        wsum    = {1'b0, i_hdr_len} + {1'b0, i_data_len};
        w_ok    = (i_data_len != 24'd0) && (wsum < {1'b0, r_buf_size});
        base_off = r_woff;
        if (r_woff >= r_buf_size) base_off = '0;
        if (wsum >= {1'b0, r_buf_size - base_off}) base_off = '0;
        wi = widx_in ? r_widx : '0;
        wdesc.offset = {1'b0, r_data_base} + {1'b0, base_off};
        wdesc.hdr  = i_hdr_len;
        wdesc.dlen = i_data_len;
        wdesc.user = i_user;
        wdesc.ts   = i_ts;
        we = accept && (t_op'(i_op) == OP_WRITE) && w_ok;
        raddr = (r_state == ST_WALK) ? r_walk : snap;
    end

    fdr_desc_ram u_ram (
        .i_clk  (i_clk),
        .i_we   (we),
        .i_waddr(wi),
        .i_wdata(wdesc),
        .i_raddr(raddr),
        .o_rdata(rdata)
    );

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (accept && t_op'(i_op) == OP_PEEK && !empty) n_state = ST_PEEK;
                else if (accept && t_op'(i_op) == OP_RANGE && !empty) n_state = ST_WALK;
            end
            ST_PEEK: n_state = ST_IDLE;
            ST_WALK: if (r_walk == r_widx) n_state = ST_DONE;
            ST_DONE: n_state = ST_IDLE;
            default: n_state = ST_IDLE;
        endcase
    end

    assign busy = (r_state != ST_IDLE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_buf_size <= 24'd65536;
            r_num_blocks <= 5'd16;
            r_data_base <= '0;
            r_widx <= '0; r_ridx <= '0; r_rvalid <= 1'b0;
            r_woff <= '0; r_wtot <= '0; r_rtot <= '0;
            r_state <= ST_IDLE; r_valid <= 1'b0; r_ok <= 1'b0;
            r_peek_out <= 1'b0; r_first <= 1'b0;
            r_offset <= '0; r_min <= '0; r_max <= '0; r_walk <= '0;
        end else begin
            r_state <= n_state;
            r_valid <= 1'b0;
            r_peek_out <= 1'b0;
            if (psel && penable && pwrite) begin
                case (cfg_addr)
                    REG_BUF_SIZE:  r_buf_size <= pwdata[23:0];
                    REG_NUM_BLK:   r_num_blocks <= pwdata[4:0];
                    REG_DATA_BASE: r_data_base <= pwdata[23:0];
                    default: ;
                endcase
            end
            if (accept) begin
                r_offset <= '0;
                r_min <= '0;
                r_max <= '0;
                r_ok <= 1'b0;
                r_valid <= 1'b1;
                case (t_op'(i_op))
                    OP_WRITE: if (w_ok) begin
                        r_ok <= 1'b1;
                        r_offset <= wdesc.offset;
                        r_wtot <= r_wtot + 1'b1;
                        r_widx <= (wi == nb_last) ? '0 : wi + 1'b1;
                        r_woff <= base_off + wsum[23:0];
                    end
                    OP_PEEK: begin
                        r_ridx <= snap; r_rvalid <= 1'b1;
                        if (!empty) r_valid <= 1'b0;
                    end
                    OP_ADV: begin
                        r_rvalid <= 1'b1;
                        if (!empty) begin
                            r_ridx <= snap_nxt;
                            r_rtot <= r_rtot + 1'b1;
                            r_ok <= 1'b1;
                        end else begin
                            r_ridx <= snap;
                        end
                    end
                    OP_BACK: begin
                        r_rvalid <= 1'b1;
                        r_ridx <= (snap == '0) ? nb_last : snap - 1'b1;
                        r_ok <= 1'b1;
                    end
                    OP_FORGET: begin
                        r_rvalid <= 1'b0;
                        r_ok <= 1'b1;
                    end
                    OP_RANGE: if (!empty) begin
                        r_valid <= 1'b0;
                        r_walk <= snap_nxt;
                        r_first <= 1'b1;
                    end
                    default: ;
                endcase
            end
            case (r_state)
                ST_PEEK: begin
                    r_valid <= 1'b1; r_ok <= 1'b1; r_peek_out <= 1'b1;
                end
                ST_WALK: begin
                    r_first <= 1'b0;
                    if (r_first || rdata.ts < r_min) r_min <= rdata.ts;
                    if (r_first || rdata.ts > r_max) r_max <= rdata.ts;
                    r_walk <= (r_walk == nb_last) ? '0 : r_walk + 1'b1;
                end
                ST_DONE: begin
                    r_valid <= 1'b1; r_ok <= 1'b1;
                end
                default: ;
            endcase
        end
    end

    always_comb begin
        o_valid = r_valid;
        o_ok = r_ok;
        o_offset = r_peek_out ? rdata.offset : r_offset;
        o_entry_hdr_len  = r_peek_out ? rdata.hdr  : '0;
        o_entry_data_len = r_peek_out ? rdata.dlen : '0;
        o_entry_user     = r_peek_out ? rdata.user : '0;
        o_entry_ts       = r_peek_out ? rdata.ts   : '0;
        o_ts_min  = r_min;
        o_ts_max  = r_max;
        o_ts_span = r_max - r_min;
        o_frames_written = r_wtot;
        o_frames_read = r_rtot;
    end
endmodule

// ----- rtl/fdr_desc_ram.sv -----
// ----------------------------------------------------------------------------
// fdr_desc_ram
// Descriptor store: one write port, one registered read port.
// ----------------------------------------------------------------------------
module fdr_desc_ram import fdr_pkg::*; (
    input  logic            i_clk,
    input  logic            i_we,
    input  logic [IdxW-1:0] i_waddr,
    input  t_desc           i_wdata,
    input  logic [IdxW-1:0] i_raddr,
    output t_desc           o_rdata
);
    t_desc r_mem [MaxBlocks];
    t_desc r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

// ----- sim/frame_descriptor_ring_tb.sv -----
// ----------------------------------------------------------------------------
// frame_descriptor_ring_tb
// Self-checking bench for the frame descriptor ring: a queue-fed command
// driver with bursty gaps, a strobe monitor comparing all reply fields as one
// struct against an in-bench ring model, and APB set-up of buffer size,
// ring length and data base between phases, extremes included.
// ----------------------------------------------------------------------------
module frame_descriptor_ring_tb import fdr_pkg::*;;
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [2:0] OP_UNDEF_A = 3'd6;
    localparam logic [2:0] OP_UNDEF_B = 3'd7;
    localparam int         SETTLE     = 40;

    typedef struct packed {
        logic [2:0]  op;
        logic [23:0] hdr;
        logic [23:0] dlen;
        logic [31:0] user;
        logic [31:0] ts;
    } t_item;

    typedef struct packed {
        logic        ok;
        logic [24:0] offset;
        logic [23:0] hdr;
        logic [23:0] dlen;
        logic [31:0] user;
        logic [31:0] ts;
        logic [31:0] ts_min;
        logic [31:0] ts_max;
        logic [31:0] ts_span;
        logic [31:0] frames_written;
        logic [31:0] frames_read;
    } t_reply;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [3:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;
    logic        start = 1'b0;
    logic        busy;
    logic [2:0]  i_op = '0;
    logic [23:0] i_hdr_len = '0;
    logic [23:0] i_data_len = '0;
    logic [31:0] i_user = '0;
    logic [31:0] i_ts = '0;
    logic        o_valid;
    t_reply      got;

    frame_descriptor_ring dut (
        .i_clk, .i_rst_n, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready,
        .start, .busy, .i_op, .i_hdr_len, .i_data_len, .i_user, .i_ts, .o_valid,
        .o_ok(got.ok), .o_offset(got.offset), .o_entry_hdr_len(got.hdr),
        .o_entry_data_len(got.dlen), .o_entry_user(got.user), .o_entry_ts(got.ts),
        .o_ts_min(got.ts_min), .o_ts_max(got.ts_max), .o_ts_span(got.ts_span),
        .o_frames_written(got.frames_written), .o_frames_read(got.frames_read)
    );

    always #5 i_clk = ~i_clk;

    // ring model state
    t_desc       ring [MaxBlocks];
    int unsigned wr_idx, rd_idx, wr_ofs, wr_total, rd_total;
    bit          rd_valid;
    int unsigned cfg_buf = 65536, cfg_nb = 16, cfg_base = 0;

    t_item       cmd_queue[$];
    t_reply      pending_replies[$];
    int          mismatches = 0;
    int          burst_left = 1, gap_left = 0;

    function automatic int unsigned blocks_used();
        if (cfg_nb < 1) return 1;
        if (cfg_nb > MaxBlocks) return MaxBlocks;
        return cfg_nb;
    endfunction

    function automatic bit pending(int unsigned r, int unsigned nb);
        return wr_idx < nb && wr_idx != r;
    endfunction

    function automatic t_reply ring_predict(t_item it);
        t_reply      r;
        int unsigned nb, w, i, p, mn, mx, steps, t;
        r = '0;
        nb = blocks_used();
        case (it.op)
            OP_WRITE: begin
                w = it.hdr + it.dlen;
                if (it.dlen != 0 && w < cfg_buf) begin
                    if (wr_ofs >= cfg_buf) wr_ofs = 0;
                    if (w >= cfg_buf - wr_ofs) wr_ofs = 0;
                    i = wr_idx;
                    if (i >= nb) i = 0;
                    ring[i].offset = 25'(cfg_base + wr_ofs);
                    ring[i].hdr = it.hdr;
                    ring[i].dlen = it.dlen;
                    ring[i].user = it.user;
                    ring[i].ts = it.ts;
                    wr_total++;
                    r.ok = 1'b1;
                    r.offset = ring[i].offset;
                    i++;
                    if (i >= nb) i = 0;
                    wr_idx = i;
                    wr_ofs = (wr_ofs + w) & 32'hFFFFFF;
                end
            end
            OP_PEEK, OP_ADV, OP_BACK: begin
                if (!rd_valid || rd_idx >= nb) begin
                    rd_idx = wr_idx;
                    rd_valid = 1'b1;
                end
                if (it.op == OP_BACK) begin
                    rd_idx = (rd_idx == 0) ? nb - 1 : rd_idx - 1;
                    r.ok = 1'b1;
                end else if (pending(rd_idx, nb)) begin
                    r.ok = 1'b1;
                    if (it.op == OP_PEEK) begin
                        r.offset = ring[rd_idx].offset;
                        r.hdr = ring[rd_idx].hdr;
                        r.dlen = ring[rd_idx].dlen;
                        r.user = ring[rd_idx].user;
                        r.ts = ring[rd_idx].ts;
                    end else begin
                        rd_idx++;
                        if (rd_idx >= nb) rd_idx = 0;
                        rd_total++;
                    end
                end
            end
            OP_FORGET: begin
                rd_valid = 1'b0;
                r.ok = 1'b1;
            end
            OP_RANGE: begin
                p = (rd_valid && rd_idx < nb) ? rd_idx : wr_idx;
                if (pending(p, nb)) begin
                    mn = ring[p].ts;
                    mx = mn;
                    steps = 0;
                    while (p != wr_idx && steps < nb) begin
                        t = ring[p].ts;
                        if (t < mn) mn = t;
                        if (t > mx) mx = t;
                        p++;
                        if (p >= nb) p = 0;
                        steps++;
                    end
                    r.ok = 1'b1;
                    r.ts_min = mn;
                    r.ts_max = mx;
                    r.ts_span = mx - mn;
                end
            end
            default: ;
        endcase
        r.frames_written = wr_total;
        r.frames_read = rd_total;
        return r;
    endfunction

    function automatic t_item mk(logic [2:0] op, logic [23:0] h, logic [23:0] d,
                                 logic [31:0] u, logic [31:0] t);
        t_item it;
        it.op = op; it.hdr = h; it.dlen = d; it.user = u; it.ts = t;
        return it;
    endfunction

    function automatic t_item rand_item();
        t_item       it;
        int unsigned p, total, cap;
        it = mk(OP_PEEK, 24'($urandom), 24'($urandom), $urandom, $urandom);
        p = $urandom_range(0, 99);
        if (p < 38 && cfg_buf >= 2) begin
            cap = (cfg_buf - 1 > 4000) ? 4000 : cfg_buf - 1;
            total = ($urandom_range(0, 9) < 7) ? $urandom_range(1, cap)
                                              : $urandom_range(1, cfg_buf - 1);
            it.op = OP_WRITE;
            it.dlen = 24'($urandom_range(1, total));
            it.hdr = 24'(total - it.dlen);
        end else if (p < 43) it.op = OP_WRITE;
        else if (p < 55) it.op = OP_PEEK;
        else if (p < 68) it.op = OP_ADV;
        else if (p < 76) it.op = OP_BACK;
        else if (p < 81) it.op = OP_FORGET;
        else if (p < 93) it.op = OP_RANGE;
        else if (p < 96) it.op = $urandom_range(0, 1) ? OP_UNDEF_A : OP_UNDEF_B;
        return it;
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            start <= 1'b0;
        end else if (!(start && busy)) begin
            if (start) pending_replies.push_back(ring_predict(
                mk(i_op, i_hdr_len, i_data_len, i_user, i_ts)));
            if (gap_left > 0) begin
                gap_left--;
                start <= 1'b0;
            end else if (cmd_queue.size() > 0) begin
                t_item it;
                it = cmd_queue.pop_front();
                i_op <= it.op;
                i_hdr_len <= it.hdr;
                i_data_len <= it.dlen;
                i_user <= it.user;
                i_ts <= it.ts;
                start <= 1'b1;
                if (--burst_left <= 0) begin
                    burst_left = $urandom_range(1, 24);
                    gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
                end
            end else begin
                start <= 1'b0;
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid) begin
            if (pending_replies.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected reply %p", got);
            end else begin
                t_reply e;
                e = pending_replies.pop_front();
                if (e !== got) begin
                    mismatches++;
                    if (mismatches <= 10) $display("mismatch: expected %p actual %p", e, got);
                end
            end
        end
    end

    task automatic reg_write(logic [1:0] idx, logic [31:0] val);
        @(posedge i_clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= 4'(idx) << 2;
        pwdata <= val;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        case (idx)
            REG_BUF_SIZE:  cfg_buf = val & 32'hFFFFFF;
            REG_NUM_BLK:   cfg_nb = val & 32'h1F;
            REG_DATA_BASE: cfg_base = val & 32'hFFFFFF;
            default: ;
        endcase
    endtask

    task automatic drain();
        while (cmd_queue.size() > 0 || start || pending_replies.size() > 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    initial begin
        int unsigned bufs[8]  = '{65536, 24'hFFFFFF, 1000, 1, 300, 5000, 24'hFFFFFF, 4096};
        int unsigned nbs[8]   = '{16, 16, 5, 3, 0, 31, 1, 16};
        int unsigned bases[8] = '{0, 24'hFFFFFF, 1234, 0, 77, 24'h800000, 12, 0};
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        for (int ph = 0; ph < 8; ph++) begin
            reg_write(REG_BUF_SIZE, bufs[ph]);
            reg_write(REG_NUM_BLK, nbs[ph] | ($urandom & 32'hFFFFFFE0));
            reg_write(REG_DATA_BASE, bases[ph]);
            if (ph == 0) begin
                // empty ring first, then fill every entry before any step back
                cmd_queue.push_back(mk(OP_PEEK, 0, 0, 0, 0));
                cmd_queue.push_back(mk(OP_ADV, 0, 0, 0, 0));
                cmd_queue.push_back(mk(OP_RANGE, 0, 0, 0, 0));
                cmd_queue.push_back(mk(OP_FORGET, 0, 0, 0, 0));
                cmd_queue.push_back(mk(OP_WRITE, 24'd5, 24'd0, $urandom, $urandom));
                cmd_queue.push_back(mk(OP_WRITE, 24'hFFFFFF, 24'hFFFFFF, '1, '1));
                for (int i = 0; i < 16; i++)
                    cmd_queue.push_back(mk(OP_WRITE, (i == 7) ? 24'd0 : 24'(i * 3),
                        (i == 7) ? 24'd65535 : (i % 4 == 0) ? 24'd20000 : 24'(i + 1),
                        (i == 2) ? 32'd0 : (i == 4) ? '1 : $urandom,
                        (i == 3) ? 32'd0 : (i == 5) ? '1 : $urandom));
                cmd_queue.push_back(mk(OP_BACK, 0, 0, 0, 0));
                cmd_queue.push_back(mk(OP_PEEK, 0, 0, 0, 0));
                cmd_queue.push_back(mk(OP_RANGE, 0, 0, 0, 0));
            end
            for (int n = 0; n < 155; n++) begin
                cmd_queue.push_back(rand_item());
                if (n == 80) begin
                    drain();
                end
            end
            drain();
        end
        if (mismatches == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

    initial begin
        #5ms;
        $display("status: fail");
        $finish;
    end
endmodule
